>>> rtl/oms_pkg.sv
// Package with the mode, event and configuration codes of the operating-mode supervisor.
`default_nettype none
package oms_pkg;

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned EVENT_W  = 4;
	localparam int unsigned SRC_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;

	// Mode codes.
	localparam logic [MODE_W-1:0] M_INIT    = 3'd0;
	localparam logic [MODE_W-1:0] M_IDLE    = 3'd1;
	localparam logic [MODE_W-1:0] M_MANUAL  = 3'd2;
	localparam logic [MODE_W-1:0] M_AUTO    = 3'd3;
	localparam logic [MODE_W-1:0] M_PAUSED  = 3'd4;
	localparam logic [MODE_W-1:0] M_FAULT   = 3'd5;
	localparam logic [MODE_W-1:0] M_TESTING = 3'd6;

	// Event codes.
	localparam logic [EVENT_W-1:0] EV_ERROR   = 4'd0;
	localparam logic [EVENT_W-1:0] EV_READY   = 4'd1;
	localparam logic [EVENT_W-1:0] EV_START   = 4'd2;
	localparam logic [EVENT_W-1:0] EV_STOP    = 4'd3;
	localparam logic [EVENT_W-1:0] EV_AUTO    = 4'd4;
	localparam logic [EVENT_W-1:0] EV_MANUAL  = 4'd5;
	localparam logic [EVENT_W-1:0] EV_TESTING = 4'd6;
	localparam logic [EVENT_W-1:0] EV_PAUSE   = 4'd7;
	localparam logic [EVENT_W-1:0] EV_RESUME  = 4'd8;
	localparam logic [EVENT_W-1:0] EV_RESET   = 4'd9;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_ID = 1'd1;

	localparam logic [SRC_W-1:0] PHYSICAL_ID_RST = 8'd1;
	localparam logic [SRC_W-1:0] EXTERNAL_ID_RST = 8'd2;

endpackage
`default_nettype wire

>>> rtl/operating_mode_supervisor.sv
// Operating-mode supervisor: source filter, mode transition table and result register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   event_code, source_id, autonomy_enabled
//   out      output     out_valid / out_stall mode, event_accepted, mode_changed,
//                                             resume_refused, invalid_mode_fault
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// An event is captured in the input register, resolved against the mode register and lands
// in the result register, one event per cycle while the result register is not stalled.
// The mode register is updated in the same cycle the event is resolved, so the following
// event sees it. After reset the mode is init and the source ids are 1 and 2.
// The input stalls only while an event is held and the result register is full and stalled.
`default_nettype none
module operating_mode_supervisor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [oms_pkg::EVENT_W-1:0]    event_code,
	input  wire logic [oms_pkg::SRC_W-1:0]      source_id,
	input  wire logic                           autonomy_enabled,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [oms_pkg::MODE_W-1:0]          mode,
	output logic                                event_accepted,
	output logic                                mode_changed,
	output logic                                resume_refused,
	output logic                                invalid_mode_fault,
	input  wire logic                           cfg_we,
	input  wire logic [oms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [oms_pkg::CFG_DATA_W-1:0] cfg_data
);
	import oms_pkg::*;

	logic [SRC_W-1:0]   physical_id_q;
	logic [SRC_W-1:0]   external_id_q;
	logic [MODE_W-1:0]  cur_mode_q;
	logic [MODE_W-1:0]  before_pause_q;
	logic [SRC_W-1:0]   pause_auth_q;

	logic               valid_s1;
	logic [EVENT_W-1:0] event_s1;
	logic [SRC_W-1:0]   src_s1;
	logic               auto_en_s1;

	logic               valid_s2;
	logic [MODE_W-1:0]  mode_s2;
	logic               accepted_s2;
	logic               changed_s2;
	logic               refused_s2;
	logic               invalid_s2;

	logic               advance;
	logic               accepted;
	logic               refused;
	logic               invalid;
	logic               take_pause;
	logic [MODE_W-1:0]  next_mode;

	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			physical_id_q <= PHYSICAL_ID_RST;
			external_id_q <= EXTERNAL_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHYSICAL_ID: physical_id_q <= cfg_data;
				CFG_EXTERNAL_ID: external_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		accepted = 1'b1;
		if (src_s1 == physical_id_q && cur_mode_q == M_AUTO)
			accepted = 1'b0;
		if (src_s1 == external_id_q && (!auto_en_s1 || cur_mode_q == M_MANUAL))
			accepted = 1'b0;
	end

	// Transition table; filtered events leave everything as it is.
	always_comb begin
		next_mode  = cur_mode_q;
		refused    = 1'b0;
		invalid    = 1'b0;
		take_pause = 1'b0;
		if (accepted) begin
			unique case (cur_mode_q)
				M_INIT: begin
					if (event_s1 == EV_ERROR)
						next_mode = M_FAULT;
					else if (event_s1 == EV_READY)
						next_mode = M_IDLE;
				end
				M_IDLE: begin
					if (event_s1 == EV_ERROR)
						next_mode = M_FAULT;
					else if (event_s1 == EV_START)
						next_mode = (src_s1 == external_id_q) ? M_AUTO : M_MANUAL;
				end
				M_MANUAL, M_AUTO: begin
					if (event_s1 == EV_STOP)
						next_mode = M_IDLE;
					else if (cur_mode_q == M_MANUAL && event_s1 == EV_AUTO)
						next_mode = M_AUTO;
					else if (cur_mode_q == M_AUTO && event_s1 == EV_MANUAL)
						next_mode = M_MANUAL;
					else if (event_s1 == EV_TESTING)
						next_mode = M_TESTING;
					else if (event_s1 == EV_ERROR)
						next_mode = M_FAULT;
					else if (event_s1 == EV_PAUSE) begin
						next_mode  = M_PAUSED;
						take_pause = 1'b1;
					end
				end
				M_PAUSED: begin
					if (event_s1 == EV_STOP)
						next_mode = M_IDLE;
					else if (event_s1 == EV_ERROR)
						next_mode = M_FAULT;
					else if (event_s1 == EV_RESUME) begin
						if (src_s1 >= pause_auth_q)
							next_mode = before_pause_q;
						else
							refused = 1'b1;
					end
				end
				M_TESTING: begin
					if (event_s1 == EV_STOP)
						next_mode = M_IDLE;
					else if (event_s1 == EV_ERROR)
						next_mode = M_FAULT;
				end
				M_FAULT: begin
					if (event_s1 == EV_RESET)
						next_mode = M_INIT;
				end
				default: begin
					next_mode = M_FAULT;
					invalid   = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q     <= M_INIT;
			before_pause_q <= M_INIT;
			pause_auth_q   <= '0;
		end else if (advance) begin
			cur_mode_q <= next_mode;
			if (take_pause) begin
				before_pause_q <= cur_mode_q;
				pause_auth_q   <= src_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			event_s1   <= event_code;
			src_s1     <= source_id;
			auto_en_s1 <= autonomy_enabled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!(valid_s2 && out_stall)) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2     <= next_mode;
			accepted_s2 <= accepted;
			changed_s2  <= (next_mode != cur_mode_q);
			refused_s2  <= refused;
			invalid_s2  <= invalid;
		end
	end

	assign out_valid          = valid_s2;
	assign mode               = mode_s2;
	assign event_accepted     = accepted_s2;
	assign mode_changed       = changed_s2;
	assign resume_refused     = refused_s2;
	assign invalid_mode_fault = invalid_s2;

endmodule
`default_nettype wire

>>> tb/oms_mode_checker.sv
// Checker that predicts the operating-mode supervisor's results and compares them with the outputs.
module oms_mode_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [oms_pkg::EVENT_W-1:0]    event_code,
	input  wire logic [oms_pkg::SRC_W-1:0]      source_id,
	input  wire logic                           autonomy_enabled,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [oms_pkg::MODE_W-1:0]     mode,
	input  wire logic                           event_accepted,
	input  wire logic                           mode_changed,
	input  wire logic                           resume_refused,
	input  wire logic                           invalid_mode_fault,
	input  wire logic                           cfg_we,
	input  wire logic [oms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [oms_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  mismatches,
	output int                                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import oms_pkg::*;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              accepted;
		logic              changed;
		logic              refused;
		logic              invalid;
	} outcome_t;

	logic [MODE_W-1:0] mode_now;
	logic [MODE_W-1:0] mode_saved;
	logic [SRC_W-1:0]  pause_level;
	logic [SRC_W-1:0]  physical_id;
	logic [SRC_W-1:0]  external_id;
	outcome_t          pending_outcomes[$];

	// Runs one event through the source filter and the transition table.
	function automatic outcome_t apply_event(input logic [EVENT_W-1:0] ev,
			input logic [SRC_W-1:0] src, input logic autonomy);
		outcome_t          o;
		logic [MODE_W-1:0] nxt;
		o = '0;
		nxt = mode_now;
		o.accepted = 1'b1;
		// A source that matches both ids has to clear both checks.
		if (src == physical_id && mode_now == M_AUTO)
			o.accepted = 1'b0;
		if (src == external_id && (!autonomy || mode_now == M_MANUAL))
			o.accepted = 1'b0;
		if (o.accepted) begin
			case (mode_now)
				M_INIT: begin
					if (ev == EV_ERROR) nxt = M_FAULT;
					else if (ev == EV_READY) nxt = M_IDLE;
				end
				M_IDLE: begin
					if (ev == EV_ERROR) nxt = M_FAULT;
					else if (ev == EV_START) nxt = (src == external_id) ? M_AUTO : M_MANUAL;
				end
				M_MANUAL, M_AUTO: begin
					if (ev == EV_STOP) nxt = M_IDLE;
					else if (mode_now == M_MANUAL && ev == EV_AUTO) nxt = M_AUTO;
					else if (mode_now == M_AUTO && ev == EV_MANUAL) nxt = M_MANUAL;
					else if (ev == EV_TESTING) nxt = M_TESTING;
					else if (ev == EV_ERROR) nxt = M_FAULT;
					else if (ev == EV_PAUSE) begin
						mode_saved = mode_now;
						pause_level = src;
						nxt = M_PAUSED;
					end
				end
				M_PAUSED: begin
					if (ev == EV_STOP) nxt = M_IDLE;
					else if (ev == EV_ERROR) nxt = M_FAULT;
					else if (ev == EV_RESUME) begin
						if (src >= pause_level) nxt = mode_saved;
						else o.refused = 1'b1;
					end
				end
				M_TESTING: begin
					if (ev == EV_STOP) nxt = M_IDLE;
					else if (ev == EV_ERROR) nxt = M_FAULT;
				end
				M_FAULT: begin
					if (ev == EV_RESET) nxt = M_INIT;
				end
				default: begin
					nxt = M_FAULT;
					o.invalid = 1'b1;
				end
			endcase
		end
		o.mode = nxt;
		o.changed = (nxt != mode_now);
		mode_now = nxt;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			mode_now = M_INIT;
			mode_saved = M_INIT;
			pause_level = '0;
			physical_id = PHYSICAL_ID_RST;
			external_id = EXTERNAL_ID_RST;
			pending_outcomes.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PHYSICAL_ID: physical_id = cfg_data;
					CFG_EXTERNAL_ID: external_id = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_outcomes.push_back(apply_event(event_code, source_id, autonomy_enabled));
			if (out_valid && !out_stall) begin
				got = '{mode, event_accepted, mode_changed, resume_refused, invalid_mode_fault};
				if (pending_outcomes.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected: mode %0d acc %b chg %b ref %b inv %b",
							$time, got.mode, got.accepted, got.changed, got.refused, got.invalid);
					mismatches++;
				end else begin
					want = pending_outcomes.pop_front();
					if (got.mode !== want.mode || got.accepted !== want.accepted ||
							got.changed !== want.changed || got.refused !== want.refused ||
							got.invalid !== want.invalid) begin
						if (mismatches < 10)
							$display({"%0t: mismatch: expected mode %0d acc %b chg %b ref %b inv %b,",
								" got mode %0d acc %b chg %b ref %b inv %b"}, $time,
								want.mode, want.accepted, want.changed, want.refused, want.invalid,
								got.mode, got.accepted, got.changed, got.refused, got.invalid);
						mismatches++;
					end
				end
			end
			outstanding <= pending_outcomes.size();
		end
	end

endmodule

>>> tb/operating_mode_supervisor_tb.sv
// Testbench top for the operating-mode supervisor: clock, reset, event stimulus and verdict.
module operating_mode_supervisor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import oms_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 305;
	localparam logic [EVENT_W-1:0] FIRST_UNUSED_EVENT = 4'd10;
	localparam logic [EVENT_W-1:0] LAST_UNUSED_EVENT = 4'd15;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [EVENT_W-1:0]    event_code;
	logic [SRC_W-1:0]      source_id;
	logic                  autonomy_enabled;
	logic                  out_valid;
	logic                  out_stall;
	logic [MODE_W-1:0]     mode;
	logic                  event_accepted;
	logic                  mode_changed;
	logic                  resume_refused;
	logic                  invalid_mode_fault;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int sender_idle_pct;
	int receiver_idle_pct;

	// Source ids per segment: extremes, swapped extremes, one id for both, reset values, two others.
	logic [SRC_W-1:0] physical_plan [SEGMENTS] = '{8'd0, 8'd255, 8'd7, 8'd1, 8'd200, 8'd90};
	logic [SRC_W-1:0] external_plan [SEGMENTS] = '{8'd255, 8'd0, 8'd7, 8'd2, 8'd3, 8'd91};

	operating_mode_supervisor uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.event_code         (event_code),
		.source_id          (source_id),
		.autonomy_enabled   (autonomy_enabled),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.mode               (mode),
		.event_accepted     (event_accepted),
		.mode_changed       (mode_changed),
		.resume_refused     (resume_refused),
		.invalid_mode_fault (invalid_mode_fault),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	oms_mode_checker checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.event_code         (event_code),
		.source_id          (source_id),
		.autonomy_enabled   (autonomy_enabled),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.mode               (mode),
		.event_accepted     (event_accepted),
		.mode_changed       (mode_changed),
		.resume_refused     (resume_refused),
		.invalid_mode_fault (invalid_mode_fault),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatches         (mismatches),
		.outstanding        (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Holds one event on the input until its transfer completes.
	task automatic send_event(input logic [EVENT_W-1:0] ev, input logic [SRC_W-1:0] src,
			input logic autonomy);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		event_code <= ev;
		source_id <= src;
		autonomy_enabled <= autonomy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Mostly real events from the configured sources, with some stray ids and unused codes.
	task automatic send_random_event(input logic [SRC_W-1:0] physical, input logic [SRC_W-1:0] external);
		logic [EVENT_W-1:0] ev;
		logic [SRC_W-1:0]   src;
		int                 pick;
		pick = $urandom_range(99);
		if (pick < 4) ev = EV_ERROR;
		else if (pick < 90) ev = EVENT_W'($urandom_range(EV_RESET, EV_READY));
		else ev = EVENT_W'($urandom_range(LAST_UNUSED_EVENT, FIRST_UNUSED_EVENT));
		pick = $urandom_range(99);
		if (pick < 35) src = physical;
		else if (pick < 70) src = external;
		else src = SRC_W'($urandom_range(255));
		send_event(ev, src, $urandom_range(99) < 80);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_source_ids(input logic [SRC_W-1:0] physical, input logic [SRC_W-1:0] external);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PHYSICAL_ID;
		cfg_data <= physical;
		@(posedge clk);
		cfg_index <= CFG_EXTERNAL_ID;
		cfg_data <= external;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		event_code = '0;
		source_id = '0;
		autonomy_enabled = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PHYSICAL_ID;
		cfg_data = '0;
		sender_idle_pct = 26;
		receiver_idle_pct = 88;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Walk through the table with the reset source ids.
		send_event(LAST_UNUSED_EVENT, 8'd0, 1'b0);
		send_event(EV_READY, PHYSICAL_ID_RST, 1'b1);
		send_event(EV_START, EXTERNAL_ID_RST, 1'b0);
		send_event(EV_START, EXTERNAL_ID_RST, 1'b1);
		send_event(EV_MANUAL, PHYSICAL_ID_RST, 1'b1);
		send_event(EV_PAUSE, EXTERNAL_ID_RST, 1'b1);
		send_event(EV_RESUME, PHYSICAL_ID_RST, 1'b0);
		send_event(EV_RESUME, 8'd255, 1'b0);
		send_event(EV_MANUAL, 8'd255, 1'b1);
		send_event(EV_START, EXTERNAL_ID_RST, 1'b1);
		send_event(EV_PAUSE, 8'd255, 1'b0);
		send_event(EV_RESUME, 8'd254, 1'b1);
		send_event(EV_RESUME, 8'd255, 1'b1);
		send_event(EV_TESTING, 8'd0, 1'b0);
		send_event(EV_READY, 8'd0, 1'b0);
		send_event(EV_STOP, 8'd0, 1'b1);
		send_event(EV_START, 8'd0, 1'b0);
		send_event(EV_AUTO, PHYSICAL_ID_RST, 1'b0);
		send_event(EV_ERROR, 8'd0, 1'b1);
		send_event(FIRST_UNUSED_EVENT, 8'd0, 1'b1);
		send_event(EV_RESET, 8'd0, 1'b0);
		send_event(EV_ERROR, 8'd255, 1'b1);
		send_event(EV_RESET, 8'd128, 1'b1);

		for (int s = 0; s < SEGMENTS; s++) begin
			wait_for_results();
			if (s == 2) begin
				sender_idle_pct = 88;
				receiver_idle_pct = 26;
			end else if (s == 4) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_source_ids(physical_plan[s], external_plan[s]);
			repeat (SEGMENT_ITEMS) send_random_event(physical_plan[s], external_plan[s]);
		end
		wait_for_results();

		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/oms_pkg.sv
rtl/operating_mode_supervisor.sv
tb/oms_mode_checker.sv
tb/operating_mode_supervisor_tb.sv
